FILE: rtl/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg: shared types and constants for the roulette wheel selection unit
// Item layouts, opcodes and field widths used by the cells and the top level.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int PopSizeDef = 16;  // default population size
  localparam int MemW       = 4;   // member_index width
  localparam int FitW       = 16;  // fitness score width
  localparam int RndW       = 31;  // random word width
  localparam int SelW       = 4;   // selected_index width

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SELECT = 1'b1
  } rws_op_e;

  typedef struct packed {
    rws_op_e           opcode;
    logic [MemW-1:0]   member_index;
    logic [FitW-1:0]   fitness_value;
    logic [RndW-1:0]   random_word;
  } rws_in_t;

  typedef struct packed {
    logic [SelW-1:0] selected_index;
    logic            sum_zero_error;
  } rws_out_t;

  // Control half of the token that walks the cell chain
  typedef struct packed {
    logic valid;  // token present in this stage
    logic found;  // a cell upstream already claimed the selection
  } rws_tok_ctl_t;

endpackage

FILE: rtl/rws_mod_unit.sv
// ----------------------------------------------------------------------------
// rws_mod_unit: bit-serial remainder unit
// Restoring division of the random word by the fitness sum, one bit a cycle.
// ----------------------------------------------------------------------------
module rws_mod_unit import rws_pkg::*; #(
  parameter int SumW = FitW + $clog2(PopSizeDef)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RndW-1:0] dividend_i,
  input  logic [SumW-1:0] divisor_i,
  output logic            done_o,
  output logic [SumW-1:0] rem_o
);

  localparam int CntW = $clog2(RndW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RndW-1:0] dvd_q;
  logic [SumW-1:0] dvs_q;
  logic [SumW-1:0] rem_q;
  logic [SumW:0]   trial;
  logic            ge;
  logic [SumW-1:0] rem_step;

  // trial stays below twice the divisor, so one compare and subtract is enough
  assign trial    = {rem_q, dvd_q[RndW-1]};
  assign ge       = trial >= {1'b0, dvs_q};
  assign rem_step = ge ? SumW'(trial - {1'b0, dvs_q}) : SumW'(trial);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(RndW - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[RndW-2:0], 1'b0};
      rem_q <= rem_step;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/rws_cell.sv
// ----------------------------------------------------------------------------
// rws_cell: one population member of the selection chain
// Holds the member's fitness and passes the walking token to the next cell.
// ----------------------------------------------------------------------------
module rws_cell import rws_pkg::*; #(
  parameter int IdxW     = $clog2(PopSizeDef),
  parameter int SumW     = FitW + $clog2(PopSizeDef),
  parameter int CELL_IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // fitness write, broadcast to every cell
  input  logic          wr_en_i,
  input  logic [MemW-1:0] wr_idx_i,
  input  logic [FitW-1:0] wr_value_i,
  output logic [FitW-1:0] fitness_o,
  // token from the previous cell
  input  rws_tok_ctl_t  tok_ctl_i,
  input  logic [IdxW-1:0] tok_idx_i,
  input  logic [SumW-1:0] tok_rem_i,
  // token to the next cell
  output rws_tok_ctl_t  tok_ctl_o,
  output logic [IdxW-1:0] tok_idx_o,
  output logic [SumW-1:0] tok_rem_o
);

  logic [FitW-1:0] fit_q;
  rws_tok_ctl_t    ctl_q;
  logic [IdxW-1:0] idx_q;
  logic [SumW-1:0] rem_q;
  logic            hit;
  logic            wr_match;

  assign wr_match = wr_en_i && (int'(wr_idx_i) == CELL_IDX);
  assign hit      = tok_ctl_i.valid && !tok_ctl_i.found && (tok_rem_i < SumW'(fit_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q <= '0;
      ctl_q <= '0;
    end else begin
      if (wr_match) begin
        fit_q <= wr_value_i;
      end
      ctl_q.valid <= tok_ctl_i.valid;
      ctl_q.found <= tok_ctl_i.found || hit;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= hit ? IdxW'(CELL_IDX) : tok_idx_i;
    // remainder only shrinks while the walk is still looking
    if (tok_ctl_i.found || hit) begin
      rem_q <= tok_rem_i;
    end else begin
      rem_q <= tok_rem_i - SumW'(fit_q);
    end
  end

  assign fitness_o = fit_q;
  assign tok_ctl_o = ctl_q;
  assign tok_idx_o = idx_q;
  assign tok_rem_o = rem_q;

endmodule

FILE: rtl/roulette_wheel_selection_unit.sv
// ----------------------------------------------------------------------------
// roulette_wheel_selection_unit: fitness-proportionate member selection
// Fitness table held in a chain of cells, remainder by a bit-serial unit.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one item at a
//   time. A write item (opcode OP_WRITE) stores a member's fitness and updates
//   the running sum in its accept cycle; it gives no result. Writes to members
//   at or beyond POP_SIZE are dropped.
//   A select item gives one result on the output channel (out_valid_o /
//   out_ready_i / out_item_o): the chosen member, or index 0 with
//   sum_zero_error set when every fitness is zero.
//   Timing: a select passes through the remainder unit (one quotient bit
//   a cycle), the token's trip down the cell chain, the hold stage and the
//   output register, in that order, before out_valid_o rises. With a ready
//   receiver the input reopens in the cycle out_valid_o rises; no new item
//   is taken while a select is in progress. A zero sum skips the remainder
//   unit and the chain and goes straight to the hold stage; a write is ready
//   again on the next cycle.
//   Reset clears the fitness table and the sum; no clearing pass is needed.
//   The output register lets a new item enter while a result waits; if the
//   receiver stalls, the next result sits in the hold stage and input stays
//   closed until the output register frees.
// ----------------------------------------------------------------------------
module roulette_wheel_selection_unit import rws_pkg::*; #(
  parameter int POP_SIZE = PopSizeDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rws_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rws_out_t out_item_o
);

  localparam int IdxW = $clog2(POP_SIZE);
  localparam int SumW = FitW + $clog2(POP_SIZE);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [SumW-1:0] sum_q, sum_d;
  rws_out_t        res_q, res_d;
  logic            out_valid_q, out_valid_d;
  rws_out_t        out_item_q;

  logic            in_acc;
  logic            wr_acc;
  logic            sel_acc;
  logic            wr_ok;
  logic [FitW-1:0] old_fit;
  logic            mod_start;
  logic            mod_done;
  logic [SumW-1:0] mod_rem;
  logic            out_load;
  logic [IdxW-1:0] end_idx;

  logic [FitW-1:0] fit_w [POP_SIZE];
  rws_tok_ctl_t    tok_ctl [POP_SIZE+1];
  logic [IdxW-1:0] tok_idx [POP_SIZE+1];
  logic [SumW-1:0] tok_rem [POP_SIZE+1];
  logic [POP_SIZE-1:0] tok_live;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_acc     = in_acc && (in_item_i.opcode == OP_WRITE);
  assign sel_acc    = in_acc && (in_item_i.opcode == OP_SELECT);

  // -- running sum: old entry out, new entry in, in the accept cycle
  assign wr_ok   = int'(in_item_i.member_index) < POP_SIZE;
  assign old_fit = wr_ok ? fit_w[IdxW'(in_item_i.member_index)] : '0;

  always_comb begin
    sum_d = sum_q;
    if (wr_acc && wr_ok) begin
      sum_d = sum_q - SumW'(old_fit) + SumW'(in_item_i.fitness_value);
    end
  end

  // -- remainder unit
  assign mod_start = sel_acc && (sum_q != '0);

  rws_mod_unit #(
    .SumW (SumW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (in_item_i.random_word),
    .divisor_i  (sum_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // -- cell chain: the token enters cell 0 as the remainder comes out
  assign tok_ctl[0].valid = mod_done;
  assign tok_ctl[0].found = 1'b0;
  assign tok_idx[0]       = '0;
  assign tok_rem[0]       = mod_rem;

  for (genvar g = 0; g < POP_SIZE; g++) begin : g_cell
    rws_cell #(
      .IdxW     (IdxW),
      .SumW     (SumW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_acc),
      .wr_idx_i   (in_item_i.member_index),
      .wr_value_i (in_item_i.fitness_value),
      .fitness_o  (fit_w[g]),
      .tok_ctl_i  (tok_ctl[g]),
      .tok_idx_i  (tok_idx[g]),
      .tok_rem_i  (tok_rem[g]),
      .tok_ctl_o  (tok_ctl[g+1]),
      .tok_idx_o  (tok_idx[g+1]),
      .tok_rem_o  (tok_rem[g+1])
    );
    assign tok_live[g] = tok_ctl[g+1].valid;
  end

  // walk running off the end clamps to the last member
  assign end_idx = tok_ctl[POP_SIZE].found ? tok_idx[POP_SIZE] : IdxW'(POP_SIZE - 1);

  // -- sequencer
  assign out_load = (state_q == S_HOLD) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (sel_acc) begin
          if (sum_q == '0) begin
            res_d.selected_index = '0;
            res_d.sum_zero_error = 1'b1;
            state_d              = S_HOLD;
          end else begin
            state_d = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (tok_ctl[POP_SIZE].valid) begin
          res_d.selected_index = SelW'(end_idx);
          res_d.sum_zero_error = 1'b0;
          state_d              = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // -- output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_item_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // -- checks
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_live))
    else $error("more than one token in the cell chain");

  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_acc |=> $stable(sum_q))
    else $error("fitness sum changed without a write item");

  a_mod_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_MOD))
    else $error("remainder finished outside the remainder phase");

  a_zero_err_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.sum_zero_error) |-> (out_item_o.selected_index == '0))
    else $error("zero-sum result carries a non-zero index");

endmodule

FILE: bench/tb_roulette_wheel_selection_unit.sv
// ----------------------------------------------------------------------------
// tb_roulette_wheel_selection_unit: self-checking bench for roulette selection
// Drives write and select items through the valid/ready input, mirrors the
// fitness table and running sum locally, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_roulette_wheel_selection_unit;
  import rws_pkg::*;

  localparam int unsigned PopSize     = PopSizeDef;
  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned DrainCycles = 100;      // well past the time a select takes
  localparam int unsigned LimitCycles = 400_000;  // many times the slowest pass
  localparam logic [RndW-1:0] RndMax  = '1;
  localparam logic [FitW-1:0] FitMax  = '1;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  rws_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rws_out_t out_item;

  // Idle percentages for the current traffic phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Local mirror of the fitness table and its exact running sum
  logic [FitW-1:0] fitness_model [PopSize] = '{default: '0};
  int unsigned     fitness_total = 0;

  // Selections predicted at acceptance, oldest first
  rws_out_t    pending_picks [$];
  int unsigned mismatch_count = 0;

  roulette_wheel_selection_unit #(
    .POP_SIZE(PopSize)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Spin the wheel: reduce the word modulo the sum, then walk the table
  // until the remainder drops below the current member's score.
  function automatic rws_out_t predict_pick(input logic [RndW-1:0] rnd);
    rws_out_t    pick;
    int unsigned rem;
    int unsigned idx;
    pick = '0;
    if (fitness_total == 0) begin
      // empty wheel: no division, index 0 with the error flag
      pick.sum_zero_error = 1'b1;
      return pick;
    end
    rem = rnd % fitness_total;
    idx = 0;
    while (idx < PopSize && rem >= fitness_model[idx]) begin
      rem -= fitness_model[idx];
      idx++;
    end
    // walk running off the end; unreachable while the sum tracks the table
    if (idx >= PopSize) idx = PopSize - 1;
    pick.selected_index = idx[SelW-1:0];
    return pick;
  endfunction

  // Bring the mirror up to date with one accepted item
  function automatic void apply_item(input rws_in_t it);
    if (it.opcode == OP_WRITE) begin
      // writes beyond the table are dropped
      if (int'(it.member_index) < PopSize) begin
        fitness_total = fitness_total - fitness_model[it.member_index] + it.fitness_value;
        fitness_model[it.member_index] = it.fitness_value;
      end
    end else begin
      pending_picks.push_back(predict_pick(it.random_word));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Offer one item, with random idle cycles first, and hold it until taken.
  // Called at a rising edge; in_valid gets at most one update per edge.
  task automatic send_item(input rws_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    apply_item(it);
  endtask

  // Write item; random_word is unused and left random
  task automatic write_fitness(input logic [MemW-1:0] member, input logic [FitW-1:0] score);
    rws_in_t it;
    it.opcode        = OP_WRITE;
    it.member_index  = member;
    it.fitness_value = score;
    it.random_word   = RndW'($urandom());
    send_item(it);
  endtask

  // Select item; member and score fields are unused and left random
  task automatic request_pick(input logic [RndW-1:0] rnd);
    rws_in_t it;
    it.opcode        = OP_SELECT;
    it.member_index  = MemW'($urandom());
    it.fitness_value = FitW'($urandom());
    it.random_word   = rnd;
    send_item(it);
  endtask

  // Close the input and wait until every predicted pick has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_picks.size() != 0) @(posedge clk);
  endtask

  // Scores biased towards zero, full scale and small values
  function automatic logic [FitW-1:0] rand_fitness();
    case ($urandom_range(7))
      0:       return '0;
      1:       return FitMax;
      2:       return FitW'($urandom_range(15));
      default: return FitW'($urandom());
    endcase
  endfunction

  // Random words, including the extremes and small values
  function automatic logic [RndW-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return RndMax;
      2:       return RndW'($urandom_range(255));
      default: return RndW'($urandom());
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Compare each taken result with the oldest prediction, then pick the
  // receiver's readiness for the next edge.
  always @(posedge clk) begin : result_check
    rws_out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d error %0b",
                                  out_item.selected_index, out_item.sum_zero_error));
      end else begin
        want = pending_picks.pop_front();
        if (out_item.selected_index !== want.selected_index)
          report_mismatch($sformatf("selected_index %0d, predicted %0d",
                                    out_item.selected_index, want.selected_index));
        if (out_item.sum_zero_error !== want.sum_zero_error)
          report_mismatch($sformatf("sum_zero_error %0b, predicted %0b",
                                    out_item.sum_zero_error, want.sum_zero_error));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty wheel straight after reset, a single member, and back to empty
  task automatic test_zero_sum();
    request_pick(RndMax);          // table cleared by reset
    write_fitness(4'd3, 16'd5);
    request_pick(RndMax);
    write_fitness(4'd3, 16'd0);
    request_pick('0);              // empty again
    write_fitness(4'd7, 16'd1);
    request_pick(RndMax);          // lone member with the smallest score
    write_fitness(4'd7, 16'd0);
  endtask

  // Remainders either side of a member's boundary, zero members skipped
  task automatic test_walk_boundaries();
    write_fitness(4'd0, FitMax);
    write_fitness(4'd15, 16'd1);
    request_pick('0);
    request_pick(RndW'(65534));
    request_pick(RndW'(65535));    // first word past member 0: lands on 15
    request_pick(RndMax);
    write_fitness(4'd8, FitMax);
    request_pick(RndW'(65535));    // lands on 8
    request_pick(RndW'(131070));   // skips 9..14 (zero) to 15
  endtask

  // Unused fields of each item type at their extremes
  task automatic test_ignored_fields();
    rws_in_t it;
    it = '{opcode: OP_WRITE, member_index: 4'd0, fitness_value: 16'd2, random_word: RndMax};
    send_item(it);
    it = '{opcode: OP_SELECT, member_index: 4'hf, fitness_value: FitMax, random_word: '0};
    send_item(it);
    it = '{opcode: OP_SELECT, member_index: '0, fitness_value: '0, random_word: RndW'(1)};
    send_item(it);
  endtask

  // Mixed writes and selects under one idle setting. Now and then the whole
  // table is zeroed so that sparse wheels and the empty wheel recur.
  task automatic test_random_traffic(input int unsigned items, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned sent;
    int unsigned roll;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < items) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        for (int m = 0; m < PopSize; m++) write_fitness(MemW'(m), '0);
        sent += PopSize;
      end else if (roll < 45) begin
        write_fitness(MemW'($urandom_range(PopSize - 1)), rand_fitness());
        sent++;
      end else begin
        request_pick(rand_word());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_sum();
    test_walk_boundaries();
    test_ignored_fields();
    test_random_traffic(135, 0, 0);    // full rate both sides
    test_random_traffic(135, 55, 0);   // sender idling
    test_random_traffic(135, 0, 55);   // receiver stalling
    test_random_traffic(135, 14, 14);  // both

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("roulette_wheel_selection_unit regression: pass");
    end else begin
      $display("roulette_wheel_selection_unit regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("roulette_wheel_selection_unit regression: fail");
    $finish;
  end

endmodule
